/* rtl/core/vmfe_pkg.sv */
// Shared types, constants and helpers for the voice mixer with fade envelope.
package vmfe_pkg;

    localparam int VOICES_DEF = 8;

    localparam int AMP_W   = 25;   // unsigned Q1.24 amplitude
    localparam int RAMP_W  = 26;   // signed Q1.24 per-frame step
    localparam int SMP_W   = 16;
    localparam int VOL_W   = 4;
    localparam int K_W     = 7;    // volume squared, 0..100
    localparam int A2_W    = 49;   // amplitude squared, at most 2^48
    localparam int GAIN_W  = A2_W + K_W;
    localparam int HALF_W  = GAIN_W / 2;
    localparam int Q_W     = 22;   // floor(mag * gain / 2^48), at most 3276800
    localparam int RECIP_W = 23;
    localparam int RECIP_SH = 29;
    localparam int VAL_W   = SMP_W + 1;

    localparam logic [AMP_W-1:0]   AMP_ONE     = AMP_W'(1 << 24);
    localparam logic [VOL_W-1:0]   VOL_MAX     = VOL_W'(10);
    // ceil(2^29 / 100): exact quotient by 100 for every Q below 2^22
    localparam logic [RECIP_W-1:0] RECIP_100   = RECIP_W'(5368710);

    typedef enum logic [1:0] {
        ACT_MIX  = 2'd0,
        ACT_AMP  = 2'd1,
        ACT_RAMP = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef enum logic [0:0] {
        CFG_SOUND = 1'b0,
        CFG_MUSIC = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_GAIN,
        ST_PROD,
        ST_SUM,
        ST_RECIP,
        ST_MERGE
    } t_state;

    typedef struct packed {
        logic sq;
        logic gain;
        logic prod;
        logic sum;
        logic recip;
        logic merge;
    } t_ctl;

    // Volume setting to its square; settings above ten act as ten.
    function automatic logic [K_W-1:0] vol_gain(input logic [VOL_W-1:0] vol);
        logic [VOL_W-1:0] v;
        v = (vol > VOL_MAX) ? VOL_MAX : vol;
        return K_W'(v) * K_W'(v);
    endfunction

endpackage

/* rtl/core/vmfe_gain.sv */
// Shared gain front end: amplitude squared, then times the volume square.
module vmfe_gain
    import vmfe_pkg::*;
(
    input  logic                i_clk,
    input  t_ctl                i_ctl,
    input  logic [AMP_W-1:0]    i_amp,
    input  logic [VOL_W-1:0]    i_vol,
    output logic [GAIN_W-1:0]   o_gain
);

    logic [2*AMP_W-1:0] w_a2_full;
    logic [A2_W-1:0]    r_a2;
    logic [GAIN_W-1:0]  r_gain;

    assign w_a2_full = (2*AMP_W)'(i_amp) * (2*AMP_W)'(i_amp);

    always_ff @(posedge i_clk) begin
        if (i_ctl.sq) begin
            r_a2 <= w_a2_full[A2_W-1:0];
        end
        if (i_ctl.gain) begin
            r_gain <= GAIN_W'(r_a2) * GAIN_W'(vol_gain(i_vol));
        end
    end

    assign o_gain = r_gain;

endmodule

/* rtl/core/vmfe_lane.sv */
// One channel lane: magnitude times gain, drop 48 fraction bits, divide by 100.
module vmfe_lane
    import vmfe_pkg::*;
(
    input  logic                    i_clk,
    input  t_ctl                    i_ctl,
    input  logic signed [SMP_W-1:0] i_sample,
    input  logic [GAIN_W-1:0]       i_gain,
    output logic signed [VAL_W-1:0] o_value
);

    localparam int PW = SMP_W + HALF_W;

    logic [SMP_W-1:0]         w_mag;
    logic [PW:0]              w_sum;
    logic [Q_W+RECIP_W-1:0]   w_qm;
    logic                     r_neg;
    logic [PW-1:0]            r_p_lo;
    logic [PW-1:0]            r_p_hi;
    logic [Q_W-1:0]           r_q;
    logic [SMP_W-1:0]         r_r;

    // -32768 maps to 0x8000, its magnitude as unsigned
    assign w_mag = i_sample[SMP_W-1] ? (~i_sample + 1'b1) : i_sample;
    assign w_sum = (PW+1)'(r_p_hi) + (PW+1)'(r_p_lo >> HALF_W);
    assign w_qm  = (Q_W+RECIP_W)'(r_q) * (Q_W+RECIP_W)'(RECIP_100);

    always_ff @(posedge i_clk) begin
        if (i_ctl.prod) begin
            r_neg  <= i_sample[SMP_W-1];
            r_p_lo <= PW'(w_mag) * PW'(i_gain[HALF_W-1:0]);
            r_p_hi <= PW'(w_mag) * PW'(i_gain[GAIN_W-1:HALF_W]);
        end
        if (i_ctl.sum) begin
            // bits above 2^48 of the full product
            r_q <= w_sum[48-HALF_W+Q_W-1:48-HALF_W];
        end
        if (i_ctl.recip) begin
            r_r <= w_qm[RECIP_SH+SMP_W-1:RECIP_SH];
        end
    end

    assign o_value = r_neg ? -$signed({1'b0, r_r}) : $signed({1'b0, r_r});

endmodule

/* rtl/core/vmfe_merge.sv */
// Merge stage: saturating accumulate of both lanes and the output register.
module vmfe_merge
    import vmfe_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctl                    i_ctl,
    input  logic                    i_add,
    input  logic                    i_first,
    input  logic                    i_last,
    input  logic                    i_faded,
    input  logic signed [VAL_W-1:0] i_value_l,
    input  logic signed [VAL_W-1:0] i_value_r,
    input  logic                    i_tready,
    output logic                    o_tvalid,
    output logic [2*SMP_W-1:0]      o_tdata,
    output logic                    o_tuser
);

    logic signed [SMP_W-1:0] r_acc_l, r_acc_r, n_acc_l, n_acc_r;
    logic signed [SMP_W-1:0] r_out_l, r_out_r;
    logic                    r_out_faded;
    logic                    r_out_valid;

    function automatic logic signed [SMP_W-1:0] sat_add(
        input logic signed [SMP_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic signed [VAL_W:0] t;
        t = (VAL_W+1)'(a) + (VAL_W+1)'(b);
        if (t > (VAL_W+1)'(32767)) begin
            return SMP_W'(32767);
        end else if (t < -(VAL_W+1)'(32768)) begin
            return SMP_W'(-32768);
        end
        return t[SMP_W-1:0];
    endfunction

    always_comb begin
        n_acc_l = i_first ? '0 : r_acc_l;
        n_acc_r = i_first ? '0 : r_acc_r;
        if (i_add) begin
            n_acc_l = sat_add(n_acc_l, i_value_l);
            n_acc_r = sat_add(n_acc_r, i_value_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_l     <= '0;
            r_acc_r     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.merge) begin
                r_acc_l <= n_acc_l;
                r_acc_r <= n_acc_r;
            end
            if (i_ctl.merge && i_last) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.merge && i_last) begin
            r_out_l     <= n_acc_l;
            r_out_r     <= n_acc_r;
            r_out_faded <= i_faded;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {r_out_r, r_out_l};
    assign o_tuser  = r_out_faded;

endmodule

/* rtl/core/voice_mixer_fade_envelope_top.sv */
// Top level of the voice mixer with per-voice linear fade envelope.
//
// Usage: stream one command per transfer on the s_axis side. tuser carries the
// action (mix frame, set amplitude, set ramp) and the stereo flag; tlast marks
// the last voice of a frame. A mix transfer with tlast set produces one mixed
// stereo frame on m_axis; set transfers and the unused action produce nothing.
// Volume registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the
// user is to write them only while the block is idle, which is not enforced.
//
// Flow: a set command is done at acceptance. A mix command runs through seven
// steps (memory read, amplitude square, volume gain, split partial products,
// fraction drop, divide by 100 through a reciprocal, saturating merge); no new
// transfer is taken until its steps are done; the frame is registered for
// m_axis in the merge step. The two channel lanes run side by side and share
// the gain front end; the dependent multiply chain sets the step count.
// Reset clears every amplitude and ramp (through valid bits), the accumulator
// and output valid, and sets both volumes to ten. If the receiver stalls, the
// finished frame holds in the output register while further transfers are
// taken; only a second frame waiting to be emitted holds the merge step.
module voice_mixer_fade_envelope_top
    import vmfe_pkg::*;
#(
    parameter int VOICES = VOICES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration write port
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_idx,
    input  logic [VOL_W-1:0]    i_cfg_data,
    // input stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // tdata from bit 0: voice[2:0], left_sample[18:3], right_sample[34:19],
    // level[59:35], ramp[85:60], first_voice[86], zero pad[87]
    input  logic [87:0]         s_axis_tdata,
    // tuser from bit 0: action[1:0], stereo[2]
    input  logic [2:0]          s_axis_tuser,
    input  logic                s_axis_tlast,    // last_voice
    // output stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // tdata from bit 0: mix_left[15:0], mix_right[31:16]
    output logic [31:0]         m_axis_tdata,
    // tuser from bit 0: music_faded[0]
    output logic [0:0]          m_axis_tuser
);

    localparam int AW = (VOICES > 1) ? $clog2(VOICES) : 1;

    // input field unpack
    logic [2:0]              w_voice;
    logic signed [SMP_W-1:0] w_left, w_right;
    logic [AMP_W-1:0]        w_level, w_level_sat;
    logic signed [RAMP_W-1:0] w_ramp;
    logic                    w_first, w_stereo;
    t_action                 w_action;
    logic                    w_accept, w_voice_ok;
    logic [AW-1:0]           w_addr;

    assign w_voice  = s_axis_tdata[2:0];
    assign w_left   = s_axis_tdata[18:3];
    assign w_right  = s_axis_tdata[34:19];
    assign w_level  = s_axis_tdata[59:35];
    assign w_ramp   = s_axis_tdata[85:60];
    assign w_first  = s_axis_tdata[86];
    assign w_action = t_action'(s_axis_tuser[1:0]);
    assign w_stereo = s_axis_tuser[2];

    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_voice_ok  = 32'(w_voice) < VOICES;
    assign w_addr      = AW'(w_voice);
    assign w_level_sat = (w_level > AMP_ONE) ? AMP_ONE : w_level;

    // configuration
    logic [VOL_W-1:0] r_sound_vol, r_music_vol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sound_vol <= VOL_MAX;
            r_music_vol <= VOL_MAX;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SOUND: r_sound_vol <= i_cfg_data;
                CFG_MUSIC: r_music_vol <= i_cfg_data;
                default:   r_sound_vol <= r_sound_vol;
            endcase
        end
    end

    // sequencer
    t_state r_state, n_state;
    t_ctl   w_ctl;
    logic   w_merge_go;

    logic                     r_voice_ok, r_first, r_last, r_is_music;
    logic [AW-1:0]            r_addr;
    logic signed [SMP_W-1:0]  r_left, r_right;
    logic [VOL_W-1:0]         r_vol;

    assign w_merge_go = !r_last || !m_axis_tvalid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_accept && w_action == ACT_MIX) begin
                n_state = ST_SQUARE;
            end
            ST_SQUARE: n_state = ST_GAIN;
            ST_GAIN:   n_state = ST_PROD;
            ST_PROD:   n_state = ST_SUM;
            ST_SUM:    n_state = ST_RECIP;
            ST_RECIP:  n_state = ST_MERGE;
            ST_MERGE:  if (w_merge_go) begin
                n_state = ST_IDLE;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_ctl         = '0;
        s_axis_tready = 1'b0;
        unique case (r_state)
            ST_IDLE:   s_axis_tready = 1'b1;
            ST_SQUARE: w_ctl.sq    = 1'b1;
            ST_GAIN:   w_ctl.gain  = 1'b1;
            ST_PROD:   w_ctl.prod  = 1'b1;
            ST_SUM:    w_ctl.sum   = 1'b1;
            ST_RECIP:  w_ctl.recip = 1'b1;
            ST_MERGE:  w_ctl.merge = w_merge_go;
            default:   w_ctl       = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // hold the mix command for the duration of its steps
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_voice_ok <= w_voice_ok;
            r_addr     <= w_addr;
            r_is_music <= (w_voice == 3'd0);
            r_first    <= w_first;
            r_last     <= s_axis_tlast;
            r_left     <= w_left;
            r_right    <= w_stereo ? w_right : w_left;
            r_vol      <= (w_voice == 3'd0) ? r_music_vol : r_sound_vol;
        end
    end

    // voice envelope memory with valid bits; an unwritten entry reads as zero
    logic [AMP_W-1:0]         m_amp [VOICES];
    logic signed [RAMP_W-1:0] m_ramp[VOICES];
    logic [VOICES-1:0]        r_amp_vld, r_ramp_vld;
    logic [AMP_W-1:0]         r_rd_amp;
    logic signed [RAMP_W-1:0] r_rd_ramp;
    logic [AMP_W-1:0]         r_amp0;
    logic signed [RAMP_W-1:0] r_ramp0;
    logic signed [RAMP_W:0]   w_next_amp_s;
    logic [AMP_W-1:0]         w_next_amp;
    logic                     w_set_amp, w_set_ramp, w_upd_amp;

    assign w_set_amp  = w_accept && w_action == ACT_AMP && w_voice_ok;
    assign w_set_ramp = w_accept && w_action == ACT_RAMP && w_voice_ok;
    assign w_upd_amp  = w_ctl.sq && r_voice_ok;

    assign w_next_amp_s = $signed({2'b00, r_rd_amp}) + (RAMP_W+1)'(r_rd_ramp);
    always_comb begin
        if (w_next_amp_s < 0) begin
            w_next_amp = '0;
        end else if (w_next_amp_s > $signed({2'b00, AMP_ONE})) begin
            w_next_amp = AMP_ONE;
        end else begin
            w_next_amp = w_next_amp_s[AMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_set_amp) begin
            m_amp[w_addr] <= w_level_sat;
        end else if (w_upd_amp) begin
            m_amp[r_addr] <= w_next_amp;
        end
        if (w_set_ramp) begin
            m_ramp[w_addr] <= w_ramp;
        end
        if (w_accept) begin
            r_rd_amp  <= r_amp_vld[w_addr]  ? m_amp[w_addr]  : '0;
            r_rd_ramp <= r_ramp_vld[w_addr] ? m_ramp[w_addr] : '0;
        end
    end

    // valid bits and the slot-zero shadow used for the faded flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp_vld  <= '0;
            r_ramp_vld <= '0;
            r_amp0     <= '0;
            r_ramp0    <= '0;
        end else begin
            if (w_set_amp) begin
                r_amp_vld[w_addr] <= 1'b1;
                if (w_voice == 3'd0) begin
                    r_amp0 <= w_level_sat;
                end
            end else if (w_upd_amp) begin
                r_amp_vld[r_addr] <= 1'b1;
                if (r_is_music) begin
                    r_amp0 <= w_next_amp;
                end
            end
            if (w_set_ramp) begin
                r_ramp_vld[w_addr] <= 1'b1;
                if (w_voice == 3'd0) begin
                    r_ramp0 <= w_ramp;
                end
            end
        end
    end

    // datapath: shared gain, two channel lanes, merge
    logic [GAIN_W-1:0]       w_gain;
    logic signed [VAL_W-1:0] w_val_l, w_val_r;
    logic                    w_faded;

    assign w_faded = (r_amp0 == '0) && r_ramp0[RAMP_W-1];

    vmfe_gain u_gain (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_amp  (r_rd_amp),
        .i_vol  (r_vol),
        .o_gain (w_gain)
    );

    vmfe_lane u_lane_l (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_sample (r_left),
        .i_gain   (w_gain),
        .o_value  (w_val_l)
    );

    vmfe_lane u_lane_r (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_sample (r_right),
        .i_gain   (w_gain),
        .o_value  (w_val_r)
    );

    vmfe_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_add     (r_voice_ok),
        .i_first   (r_first),
        .i_last    (r_last),
        .i_faded   (w_faded),
        .i_value_l (w_val_l),
        .i_value_r (w_val_r),
        .i_tready  (m_axis_tready),
        .o_tvalid  (m_axis_tvalid),
        .o_tdata   (m_axis_tdata),
        .o_tuser   (m_axis_tuser[0])
    );

endmodule
